/* hdl/assert_macros.svh */
// Assertion macros shared by the deframer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition holds at every clock edge outside reset.
`define CPD_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: assertion failed");
// Consequent holds in the same cycle as the antecedent.
`define CPD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");
// Consequent holds in the cycle after the antecedent.
`define CPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
`else
`define CPD_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define CPD_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CPD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hdl/cpd_pkg.sv */
// Types, constants and the payload hash of the checked packet deframer.
package cpd_pkg;

   localparam int MAX_FRAME_BYTES = 65536;
   localparam int HEADER_BYTES    = 16;

   localparam int HDR_IDX_W = $clog2(HEADER_BYTES + 1);
   localparam int PCOUNT_W  = $clog2(MAX_FRAME_BYTES + 1);

   // Result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_HASH = 2'd1,
      STATUS_LEN  = 2'd2
   } status_type;

   typedef struct packed {
      logic               item_kind;
      logic [7:0]         payload_byte;
      logic signed [31:0] frame_opcode;
      logic [15:0]        frame_length;
      logic signed [31:0] reserve_word;
      status_type         frame_status;
      logic               last_of_run;
   } result_type;

   // Results produced by one accepted byte: zero, one or two
   typedef struct packed {
      logic [1:0] num;
      result_type first;
      result_type second;
   } push_type;

   // One step of the alternating shift-xor hash
   function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b,
                                             input logic odd);
      logic [31:0] mix;
      if (!odd) begin
         mix = (h << 7) ^ {24'd0, b} ^ (h >> 3);
      end else begin
         mix = ~((h << 11) ^ {24'd0, b} ^ (h >> 5));
      end
      return h ^ mix;
   endfunction

endpackage

/* hdl/cpd_ifs.sv */
// Valid/ready channel interfaces for received bytes and deframer results.
interface cpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       chunk_end;

   modport source (output valid, output rx_byte, output chunk_end, input ready);
   modport sink (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface cpd_rsp_if;
   logic               valid;
   logic               ready;
   logic               item_kind;
   logic [7:0]         payload_byte;
   logic signed [31:0] frame_opcode;
   logic [15:0]        frame_length;
   logic signed [31:0] reserve_word;
   logic [1:0]         frame_status;
   logic               last_of_run;

   modport source (output valid, output item_kind, output payload_byte, output frame_opcode,
                   output frame_length, output reserve_word, output frame_status,
                   output last_of_run, input ready);
   modport sink (input valid, input item_kind, input payload_byte, input frame_opcode,
                 input frame_length, input reserve_word, input frame_status,
                 input last_of_run, output ready);
endinterface

/* hdl/cpd_core.sv */
// Header parser, payload hash and frame status logic of the deframer.
`include "assert_macros.svh"
module cpd_core (
   input  logic             clock,
   input  logic             reset,
   cpd_req_if.sink          req,
   input  logic             space_ok,
   output cpd_pkg::push_type push
);

   logic [cpd_pkg::HDR_IDX_W-1:0] hdr_idx_ff, hdr_idx_in;
   logic [31:0]                   opcode_ff, opcode_in;
   logic [31:0]                   size_ff, size_in;
   logic [31:0]                   reserve_ff, reserve_in;
   logic [31:0]                   check_ff, check_in;
   logic [cpd_pkg::PCOUNT_W-1:0]  pcount_ff, pcount_in;
   logic [31:0]                   hash_ff, hash_in;
   logic                          dropping_ff, dropping_in;

   logic                          fire;
   logic                          hdr_last;
   logic                          bad_len;
   logic [cpd_pkg::PCOUNT_W-1:0]  pcount_next;
   logic [31:0]                   hash_next;
   cpd_pkg::status_type           status;
   cpd_pkg::result_type           res_pay;
   cpd_pkg::result_type           res_stat;

   assign req.ready = space_ok;
   assign fire      = req.valid && req.ready;

   assign hdr_last    = (hdr_idx_ff == cpd_pkg::HDR_IDX_W'(cpd_pkg::HEADER_BYTES - 1));
   assign bad_len     = size_ff[31] ||
                        ((33'(size_ff) + 33'(cpd_pkg::HEADER_BYTES)) >
                         33'(cpd_pkg::MAX_FRAME_BYTES));
   assign pcount_next = pcount_ff + cpd_pkg::PCOUNT_W'(1);
   assign hash_next   = cpd_pkg::hash_step(hash_ff, req.rx_byte, pcount_ff[0]);

   // Decode header, hash payload and build results for one transfer
   always_comb begin
      hdr_idx_in  = hdr_idx_ff;
      opcode_in   = opcode_ff;
      size_in     = size_ff;
      reserve_in  = reserve_ff;
      check_in    = check_ff;
      pcount_in   = pcount_ff;
      hash_in     = hash_ff;
      dropping_in = dropping_ff;
      status      = cpd_pkg::STATUS_OK;

      res_pay.item_kind    = cpd_pkg::KIND_PAYLOAD;
      res_pay.payload_byte = req.rx_byte;
      res_pay.frame_opcode = opcode_ff;
      res_pay.frame_length = size_ff[15:0];
      res_pay.reserve_word = reserve_ff;
      res_pay.frame_status = cpd_pkg::STATUS_OK;
      res_pay.last_of_run  = 1'b1;
      res_stat             = res_pay;
      res_stat.item_kind    = cpd_pkg::KIND_STATUS;
      res_stat.payload_byte = 8'd0;

      push.num    = 2'd0;
      push.first  = res_pay;
      push.second = res_stat;

      if (fire) begin
         priority if (dropping_ff) begin
            // Drop until the chunk ends
            if (req.chunk_end) begin
               dropping_in = 1'b0;
               hdr_idx_in  = '0;
               pcount_in   = '0;
               hash_in     = '0;
            end
         end else if (!hdr_idx_ff[cpd_pkg::HDR_IDX_W-1]) begin
            // Shift the byte into its header word
            unique case (hdr_idx_ff[3:2])
               2'd0:    opcode_in  = {opcode_ff[23:0], req.rx_byte};
               2'd1:    size_in    = {size_ff[23:0], req.rx_byte};
               2'd2:    reserve_in = {reserve_ff[23:0], req.rx_byte};
               default: check_in   = {check_ff[23:0], req.rx_byte};
            endcase
            hdr_idx_in = hdr_idx_ff + cpd_pkg::HDR_IDX_W'(1);
            if (hdr_last && (bad_len || size_ff == 32'd0)) begin
               if (bad_len) begin
                  status = cpd_pkg::STATUS_LEN;
               end else if (hash_ff == check_in) begin
                  status = cpd_pkg::STATUS_OK;
               end else begin
                  status = cpd_pkg::STATUS_HASH;
               end
               res_stat.frame_length = 16'd0;
               res_stat.frame_status = status;
               push.num   = 2'd1;
               push.first = res_stat;
               hdr_idx_in = '0;
               pcount_in  = '0;
               hash_in    = '0;
               if (status != cpd_pkg::STATUS_OK && !req.chunk_end) begin
                  dropping_in = 1'b1;
               end
            end
         end else begin
            // Pass the payload byte and close the frame on its last byte
            hash_in   = hash_next;
            pcount_in = pcount_next;
            if (32'(pcount_next) >= size_ff) begin
               status = (hash_next == check_ff) ? cpd_pkg::STATUS_OK : cpd_pkg::STATUS_HASH;
               res_pay.last_of_run   = 1'b0;
               res_stat.frame_status = status;
               push.num    = 2'd2;
               push.first  = res_pay;
               push.second = res_stat;
               hdr_idx_in  = '0;
               pcount_in   = '0;
               hash_in     = '0;
               if (status != cpd_pkg::STATUS_OK && !req.chunk_end) begin
                  dropping_in = 1'b1;
               end
            end else begin
               push.num   = 2'd1;
               push.first = res_pay;
            end
         end
      end
   end

   // Hold frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_idx_ff  <= '0;
         opcode_ff   <= '0;
         size_ff     <= '0;
         reserve_ff  <= '0;
         check_ff    <= '0;
         pcount_ff   <= '0;
         hash_ff     <= '0;
         dropping_ff <= 1'b0;
      end else begin
         hdr_idx_ff  <= hdr_idx_in;
         opcode_ff   <= opcode_in;
         size_ff     <= size_in;
         reserve_ff  <= reserve_in;
         check_ff    <= check_in;
         pcount_ff   <= pcount_in;
         hash_ff     <= hash_in;
         dropping_ff <= dropping_in;
      end
   end

   `CPD_ASSERT_ALWAYS(a_hdr_idx_range, clock, reset, hdr_idx_ff <= cpd_pkg::HDR_IDX_W'(cpd_pkg::HEADER_BYTES))
   `CPD_ASSERT_IMPLY(a_drop_clean, clock, reset, dropping_ff, hdr_idx_ff == '0 && pcount_ff == '0 && push.num == 2'd0)
   `CPD_ASSERT_IMPLY(a_pair_order, clock, reset, push.num == 2'd2, push.first.item_kind == cpd_pkg::KIND_PAYLOAD && push.second.item_kind == cpd_pkg::KIND_STATUS)
   `CPD_ASSERT_IMPLY(a_payload_after_hdr, clock, reset, pcount_ff != '0, hdr_idx_ff == cpd_pkg::HDR_IDX_W'(cpd_pkg::HEADER_BYTES))

endmodule

/* hdl/cpd_rsp_fifo.sv */
// Result queue that takes up to two results a cycle and hands out one.
`include "assert_macros.svh"
module cpd_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  cpd_pkg::push_type push,
   output logic              space_ok,
   cpd_rsp_if.source         rsp
);

   cpd_pkg::result_type           mem [cpd_pkg::RSP_DEPTH];
   logic [cpd_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cpd_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cpd_pkg::RSP_CNT_W-1:0] count_ff, count_in;
   logic                          pop;
   cpd_pkg::result_type           head;

   // Room for the two results a byte can cause
   assign space_ok = (count_ff <= cpd_pkg::RSP_CNT_W'(cpd_pkg::RSP_DEPTH - 2));
   assign pop      = rsp.valid && rsp.ready;
   assign head     = mem[rd_ptr_ff];

   assign rsp.valid        = (count_ff != '0);
   assign rsp.item_kind    = head.item_kind;
   assign rsp.payload_byte = head.payload_byte;
   assign rsp.frame_opcode = head.frame_opcode;
   assign rsp.frame_length = head.frame_length;
   assign rsp.reserve_word = head.reserve_word;
   assign rsp.frame_status = head.frame_status;
   assign rsp.last_of_run  = head.last_of_run;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + cpd_pkg::RSP_PTR_W'(push.num);
      rd_ptr_in = rd_ptr_ff + cpd_pkg::RSP_PTR_W'(pop);
      count_in  = count_ff + cpd_pkg::RSP_CNT_W'(push.num) - cpd_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store incoming results
   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         mem[wr_ptr_ff + cpd_pkg::RSP_PTR_W'(1)] <= push.second;
      end
   end

   `CPD_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= cpd_pkg::RSP_CNT_W'(cpd_pkg::RSP_DEPTH))
   `CPD_ASSERT_IMPLY(a_push_has_room, clock, reset, push.num != 2'd0, space_ok)
   `CPD_ASSERT_ALWAYS(a_push_num, clock, reset, push.num != 2'd3)
   `CPD_ASSERT_NEXT(a_count_track, clock, reset, push.num == 2'd0 && !pop, count_ff == $past(count_ff))

endmodule

/* hdl/checked_packet_deframer_top.sv */
// Top level of the checked packet deframer.
//
// Takes one received byte per cycle on req while req.ready is high and emits
// payload bytes and frame status records on rsp. Each frame is a 16-byte
// big-endian header (opcode, size, reserve, check) followed by size payload
// bytes, hashed with a 32-bit shift-xor hash; the frame ends with a status
// record: ok, hash mismatch, or bad length (negative size or size + 16 over
// 65536 bytes). After an error, bytes are dropped until a byte marked
// chunk_end. A byte is decoded in the cycle it transfers and its results are
// visible on rsp from the next cycle. The last payload byte of a frame yields
// two results, which leave one at a time from a four-entry result queue.
// req.ready is low while that queue holds three or more results.
module checked_packet_deframer_top (
   input logic       clock,
   input logic       reset,
   cpd_req_if.sink   req,
   cpd_rsp_if.source rsp
);

   cpd_pkg::push_type push;
   logic              space_ok;

   cpd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .space_ok (space_ok),
      .push     (push)
   );

   cpd_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp      (rsp)
   );

endmodule

/* tb/checked_packet_deframer_top_tb.sv */
// Self-checking testbench for the checked packet deframer.
module checked_packet_deframer_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       chunk_end;
   } stream_byte_type;

   localparam int STREAM_BYTES = 650;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_PAYLOAD  = cpd_pkg::MAX_FRAME_BYTES - cpd_pkg::HEADER_BYTES;

   logic clock;
   logic reset;

   cpd_req_if req_ch();
   cpd_rsp_if rsp_ch();

   checked_packet_deframer_top DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Byte stream waiting to be sent, and deframed results still owed by the block
   stream_byte_type      rx_stream[$];
   cpd_pkg::result_type  deframed_q[$];

   bit              stream_built;
   int              stream_total;
   int              bytes_taken;
   int              phase_one_end;
   int              phase_two_end;
   int              mismatch_count;
   stream_byte_type next_byte;

   // Deframer state as the block should hold it
   logic [4:0]  hdr_count;
   logic [31:0] opcode_r;
   logic [31:0] size_r;
   logic [31:0] reserve_r;
   logic [31:0] check_r;
   logic [16:0] pay_count;
   logic [31:0] hash_r;
   logic        drop_r;

   // One step of the alternating shift-xor payload hash
   function automatic logic [31:0] mix_hash(logic [31:0] h, logic [7:0] b, logic odd);
      if (odd) return h ^ ~((h << 11) ^ {24'd0, b} ^ (h >> 5));
      return h ^ ((h << 7) ^ {24'd0, b} ^ (h >> 3));
   endfunction

   function automatic cpd_pkg::result_type build_result(logic kind, logic [7:0] b,
                                                        logic [15:0] len,
                                                        cpd_pkg::status_type st, logic fin);
      cpd_pkg::result_type r;
      r.item_kind    = kind;
      r.payload_byte = b;
      r.frame_opcode = opcode_r;
      r.frame_length = len;
      r.reserve_word = reserve_r;
      r.frame_status = st;
      r.last_of_run  = fin;
      return r;
   endfunction

   // Close the frame; an error starts dropping unless this byte ends the chunk
   function automatic void close_frame(cpd_pkg::status_type st, logic at_end);
      if (st != cpd_pkg::STATUS_OK && !at_end) drop_r = 1'b1;
      hdr_count = '0;
      pay_count = '0;
      hash_r    = '0;
   endfunction

   // Advance the deframer by one accepted byte and queue the results it owes
   function automatic void deframe_byte(logic [7:0] b, logic at_end);
      cpd_pkg::status_type st;
      logic                done;
      if (drop_r) begin
         if (at_end) begin
            drop_r = 1'b0;
            close_frame(cpd_pkg::STATUS_OK, 1'b1);
         end
         return;
      end
      if (hdr_count < cpd_pkg::HEADER_BYTES) begin
         unique case (hdr_count[3:2])
            2'd0: opcode_r = {opcode_r[23:0], b};
            2'd1: size_r = {size_r[23:0], b};
            2'd2: reserve_r = {reserve_r[23:0], b};
            default: check_r = {check_r[23:0], b};
         endcase
         hdr_count = hdr_count + 5'd1;
         if (hdr_count < cpd_pkg::HEADER_BYTES) return;
         if (size_r[31] || (64'(size_r) + 64'(cpd_pkg::HEADER_BYTES) >
                            64'(cpd_pkg::MAX_FRAME_BYTES))) begin
            deframed_q.push_back(build_result(cpd_pkg::KIND_STATUS, 8'd0, 16'd0,
                                              cpd_pkg::STATUS_LEN, 1'b1));
            close_frame(cpd_pkg::STATUS_LEN, at_end);
         end else if (size_r == 32'd0) begin
            st = (hash_r == check_r) ? cpd_pkg::STATUS_OK : cpd_pkg::STATUS_HASH;
            deframed_q.push_back(build_result(cpd_pkg::KIND_STATUS, 8'd0, 16'd0, st, 1'b1));
            close_frame(st, at_end);
         end
         return;
      end
      hash_r    = mix_hash(hash_r, b, pay_count[0]);
      pay_count = pay_count + 17'd1;
      done      = ({15'd0, pay_count} >= size_r);
      deframed_q.push_back(build_result(cpd_pkg::KIND_PAYLOAD, b, size_r[15:0],
                                        cpd_pkg::STATUS_OK, !done));
      if (done) begin
         st = (hash_r == check_r) ? cpd_pkg::STATUS_OK : cpd_pkg::STATUS_HASH;
         deframed_q.push_back(build_result(cpd_pkg::KIND_STATUS, 8'd0, size_r[15:0], st,
                                           1'b1));
         close_frame(st, at_end);
      end
   endfunction

   // Append one frame; corrupt flips a check bit, err_at_end marks the failing byte
   task automatic add_frame(logic [31:0] opcode, logic [31:0] size, logic [31:0] reserve,
                            bit corrupt, int split_pct, bit err_at_end);
      logic [7:0]   body[$];
      logic [127:0] hdr;
      logic [31:0]  h;
      logic [31:0]  chk;
      logic [7:0]   b;
      logic         flag;
      bit           bad_len;
      bit           err;
      int           n;
      bad_len = size[31] || (size > MAX_PAYLOAD);
      h = '0;
      if (!bad_len) begin
         for (int i = 0; i < int'(size); i++) begin
            b = 8'($urandom);
            body.push_back(b);
            h = mix_hash(h, b, i[0]);
         end
      end
      chk = corrupt ? (h ^ (32'd1 << $urandom_range(31))) : h;
      err = bad_len || corrupt;
      hdr = {opcode, size, reserve, chk};
      n = cpd_pkg::HEADER_BYTES + body.size();
      for (int k = 0; k < n; k++) begin
         b = (k < cpd_pkg::HEADER_BYTES) ? hdr[127 - 8*k -: 8]
                                         : body[k - cpd_pkg::HEADER_BYTES];
         if (k == n - 1 && err) flag = err_at_end;
         else flag = ($urandom_range(99) < split_pct);
         rx_stream.push_back('{rx_byte: b, chunk_end: flag});
      end
      // Resync: junk that the block drops, closed by a chunk end
      if (err && !err_at_end) begin
         repeat ($urandom_range(6)) rx_stream.push_back('{rx_byte: 8'($urandom), chunk_end: 1'b0});
         rx_stream.push_back('{rx_byte: 8'($urandom), chunk_end: 1'b1});
      end
   endtask

   function automatic int send_idle_pct();
      if (bytes_taken < phase_one_end) return 37;
      if (bytes_taken < phase_two_end) return 69;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (bytes_taken < phase_one_end) return 69;
      if (bytes_taken < phase_two_end) return 37;
      return 0;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h actual %h", $realtime, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reset and known input values from time zero
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.rx_byte   = 8'd0;
      req_ch.chunk_end = 1'b0;
      rsp_ch.ready     = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Build the byte stream: directed frames, then random frames
   initial begin
      int          sel;
      logic [31:0] sz;
      hdr_count      = '0;
      opcode_r       = '0;
      size_r         = '0;
      reserve_r      = '0;
      check_r        = '0;
      pay_count      = '0;
      hash_r         = '0;
      drop_r         = 1'b0;
      mismatch_count = 0;
      bytes_taken    = 0;
      stream_built   = 1'b0;

      add_frame(32'h0000_0000, 32'd1, 32'h0000_0000, 1'b0, 0, 1'b0);
      add_frame(32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFF, 1'b0, 0, 1'b1);
      // empty payload, good and bad check
      add_frame(32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 1'b0, 0, 1'b0);
      add_frame(32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 1'b1, 0, 1'b0);
      add_frame(32'h0000_0001, 32'd0, 32'h0000_0001, 1'b1, 0, 1'b1);
      // hash mismatch with and without a chunk end on the last byte
      add_frame($urandom, 32'd3, $urandom, 1'b1, 0, 1'b0);
      add_frame($urandom, 32'd3, $urandom, 1'b1, 0, 1'b1);
      // bad length: negative sizes, one byte over the buffer and the largest positive size
      add_frame($urandom, 32'h8000_0000, $urandom, 1'b0, 0, 1'b0);
      add_frame($urandom, 32'hFFFF_FFFF, $urandom, 1'b0, 0, 1'b1);
      add_frame($urandom, 32'(MAX_PAYLOAD + 1), $urandom, 1'b0, 0, 1'b0);
      add_frame($urandom, 32'h7FFF_FFFF, $urandom, 1'b0, 0, 1'b1);
      // frames split over many chunks
      add_frame($urandom, 32'd5, $urandom, 1'b0, 50, 1'b0);
      add_frame($urandom, 32'd4, $urandom, 1'b1, 100, 1'b0);
      add_frame($urandom, 32'd6, $urandom, 1'b0, 100, 1'b1);

      // Random frames: mostly well formed, some mismatches and bad lengths
      sz = 32'd0;
      while (rx_stream.size() < STREAM_BYTES) begin
         sel = $urandom_range(99);
         if (sel < 90) begin
            sz = ($urandom_range(3) == 0) ? 32'($urandom_range(13, 48))
                                          : 32'($urandom_range(0, 12));
         end else if ($urandom_range(1) == 0) begin
            sz = $urandom | 32'h8000_0000;
         end else begin
            sz = 32'(MAX_PAYLOAD + 1) + 32'($urandom_range(0, 32'h7FFE_0000));
         end
         add_frame($urandom, sz, $urandom, (sel >= 72 && sel < 90), $urandom_range(15),
                   1'($urandom_range(1)));
      end

      phase_one_end = rx_stream.size() / 3;
      phase_two_end = (2 * rx_stream.size()) / 3;
      stream_total  = rx_stream.size();
      stream_built  = 1'b1;

      @(negedge reset);
      while (bytes_taken < stream_total || deframed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (deframed_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $realtime, deframed_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Driver: predict on each transfer, then offer the next byte or idle
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            deframe_byte(req_ch.rx_byte, req_ch.chunk_end);
            bytes_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (stream_built && rx_stream.size() != 0 &&
                $urandom_range(99) >= send_idle_pct()) begin
               next_byte         = rx_stream.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.rx_byte   <= next_byte.rx_byte;
               req_ch.chunk_end <= next_byte.chunk_end;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct());
      end
   end

   // Monitor: compare each result transfer with the oldest owed result
   always @(posedge clock) begin
      cpd_pkg::result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (deframed_q.size() == 0) begin
            $display("%0t: unexpected result: expected none actual kind %h byte %h status %h",
                     $realtime, rsp_ch.item_kind, rsp_ch.payload_byte, rsp_ch.frame_status);
            mismatch_count++;
         end else begin
            want = deframed_q.pop_front();
            check_field("item_kind", 32'(want.item_kind), 32'(rsp_ch.item_kind));
            check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_ch.payload_byte));
            check_field("frame_opcode", want.frame_opcode, rsp_ch.frame_opcode);
            check_field("frame_length", 32'(want.frame_length), 32'(rsp_ch.frame_length));
            check_field("reserve_word", want.reserve_word, rsp_ch.reserve_word);
            check_field("frame_status", 32'(want.frame_status), 32'(rsp_ch.frame_status));
            check_field("last_of_run", 32'(want.last_of_run), 32'(rsp_ch.last_of_run));
         end
      end
   end

   // Run limit
   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/cpd_pkg.sv
hdl/cpd_ifs.sv
hdl/cpd_core.sv
hdl/cpd_rsp_fifo.sv
hdl/checked_packet_deframer_top.sv
tb/checked_packet_deframer_top_tb.sv
